/* src/rbc_pkg.sv */
// rbc_pkg: shared types for the rotor byte cipher
// item kind codes and sequencer state encoding; no dependencies

package rbc_pkg;

  typedef enum logic [2:0] {
    KIND_ENC     = 3'd0,
    KIND_DEC     = 3'd1,
    KIND_TABLE   = 3'd2,
    KIND_START   = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_TAIL = 5'b00100,
    S_STEP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam int unsigned ROTORS_RESET = 6;

endpackage

/* src/rotor_byte_cipher.sv */
// Rotor byte cipher: encrypt and decrypt bytes through up to MAX_ROTORS rotors,
// plus table, rotor start and restart items. Uses rbc_pkg for kinds and states.
// APB-style port holds rotors_in_use at byte address 0.

// Each item is taken while the block is idle. Table loads, rotor start loads,
// restarts and unused kinds go straight to the done state and give their result
// (zero byte, out_is_data low) from there through the output register. An encrypt
// or decrypt item of n active rotors runs one forward or inverse table read per
// rotor, chained through the registered read port of the table memory, a tail
// state to collect the last read, one position advance per rotor through a single
// 8-bit adder pair with carry, and a done state that loads the output register,
// then returns to idle. A stalled output holds the item in the done state. in_stall
// stays high from acceptance until the result is in the output register; the
// output register lets a new item be taken while the last result still waits.
// Tables hold undefined values until loaded.

module rotor_byte_cipher #(
  parameter int MAX_ROTORS = 8
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [2:0]  rotor_index,
  input  logic [7:0]  table_index,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  step_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data
);

  localparam int RW    = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int CW    = $clog2(MAX_ROTORS + 1);
  localparam int AW    = RW + 8;
  localparam int DEPTH = MAX_ROTORS * 256;

  rbc_pkg::state_t state;

  logic [3:0]    rotors_in_use;
  logic [CW-1:0] nact;
  logic [RW-1:0] last_idx;

  logic [7:0] pos      [MAX_ROTORS];
  logic [7:0] start_pos[MAX_ROTORS];
  logic [7:0] adv      [MAX_ROTORS];

  logic [7:0] fwd_mem [DEPTH];
  logic [7:0] inv_mem [DEPTH];
  logic [7:0] rd_fwd;
  logic [7:0] rd_inv;

  logic [RW-1:0] idx;
  logic          first;
  logic          dec_r;
  logic [7:0]    data_r;
  logic [7:0]    prev_pos;
  logic [7:0]    res;
  logic          res_is_data;
  logic          carry;

  logic          accept;
  logic          cfg_wr;
  logic          rot_ok;
  logic [RW+2:0] rot_wide;
  logic [RW-1:0] rot_w;
  logic [7:0]    b_in;
  logic [AW-1:0] addr_f;
  logic [AW-1:0] addr_i;
  logic [7:0]    inc;
  logic [8:0]    sum;
  logic          out_load;
  logic          is_cipher;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? {28'd0, rotors_in_use} : 32'd0;

  assign in_stall = (state != rbc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_cipher = (kind == rbc_pkg::KIND_ENC) || (kind == rbc_pkg::KIND_DEC);

  assign rot_wide = (RW + 3)'(rotor_index);
  assign rot_w    = rot_wide[RW-1:0];
  assign rot_ok   = (32'(rotor_index) < MAX_ROTORS);

  always_comb begin
    if (rotors_in_use == 4'd0) begin
      nact = CW'(1);
    end else if (32'(rotors_in_use) > MAX_ROTORS) begin
      nact = CW'(MAX_ROTORS);
    end else begin
      nact = CW'(rotors_in_use);
    end
  end
  assign last_idx = RW'(nact - CW'(1));

  // chained lookup address
  always_comb begin
    if (first) begin
      b_in = data_r;
    end else if (dec_r) begin
      b_in = prev_pos ^ rd_inv;
    end else begin
      b_in = rd_fwd;
    end
    addr_f = {idx, pos[idx] ^ b_in};
    addr_i = {idx, b_in};
  end

  // position advance
  assign inc = pos[idx] + {7'd0, carry};
  assign sum = {1'b0, inc} + {1'b0, adv[idx]};

  assign out_load = (state == rbc_pkg::S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (accept && (kind == rbc_pkg::KIND_TABLE) && rot_ok) begin
      fwd_mem[{rot_w, table_index}] <= data_byte;
      inv_mem[{rot_w, data_byte}]   <= table_index;
    end
    rd_fwd <= fwd_mem[addr_f];
    rd_inv <= inv_mem[addr_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotors_in_use <= 4'(rbc_pkg::ROTORS_RESET);
    end else if (cfg_wr) begin
      rotors_in_use <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROTORS; i++) begin
        pos[i]       <= 8'd0;
        start_pos[i] <= 8'd0;
        adv[i]       <= 8'd1;
      end
    end else begin
      if (accept && (kind == rbc_pkg::KIND_START) && rot_ok) begin
        start_pos[rot_w] <= data_byte;
        adv[rot_w]       <= step_value;
      end
      if (accept && (kind == rbc_pkg::KIND_RESTART)) begin
        for (int i = 0; i < MAX_ROTORS; i++) begin
          pos[i] <= start_pos[i];
        end
      end else if (state == rbc_pkg::S_STEP) begin
        pos[idx] <= sum[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbc_pkg::S_IDLE;
      idx   <= '0;
      first <= 1'b0;
      carry <= 1'b0;
    end else begin
      unique case (state)
        rbc_pkg::S_IDLE: begin
          if (accept) begin
            dec_r       <= (kind == rbc_pkg::KIND_DEC);
            data_r      <= data_byte;
            first       <= 1'b1;
            res         <= 8'd0;
            res_is_data <= is_cipher;
            idx         <= (kind == rbc_pkg::KIND_DEC) ? last_idx : '0;
            state       <= is_cipher ? rbc_pkg::S_LOOK : rbc_pkg::S_DONE;
          end
        end
        rbc_pkg::S_LOOK: begin
          first    <= 1'b0;
          prev_pos <= pos[idx];
          if (dec_r) begin
            if (idx == '0) begin
              state <= rbc_pkg::S_TAIL;
            end else begin
              idx <= idx - RW'(1);
            end
          end else begin
            if (idx == last_idx) begin
              state <= rbc_pkg::S_TAIL;
            end else begin
              idx <= idx + RW'(1);
            end
          end
        end
        rbc_pkg::S_TAIL: begin
          res   <= dec_r ? (prev_pos ^ rd_inv) : rd_fwd;
          idx   <= '0;
          carry <= 1'b0;
          state <= rbc_pkg::S_STEP;
        end
        rbc_pkg::S_STEP: begin
          carry <= sum[8];
          if (idx == last_idx) begin
            state <= rbc_pkg::S_DONE;
          end else begin
            idx <= idx + RW'(1);
          end
        end
        rbc_pkg::S_DONE: begin
          if (out_load) begin
            state <= rbc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= rbc_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= res;
      out_is_data <= res_is_data;
    end
  end

`ifndef SYNTHESIS
  a_cipher_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    accept && is_cipher |=> state == rbc_pkg::S_LOOK)
    else $error("cipher item did not start table lookups");

  a_load_goes_done: assert property (@(posedge clk) disable iff (rst)
    accept && !is_cipher |=> state == rbc_pkg::S_DONE)
    else $error("non-cipher item did not go straight to result");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rbc_pkg::S_LOOK || state == rbc_pkg::S_STEP) |-> idx <= last_idx)
    else $error("rotor counter beyond active rotors");

  a_step_ends_done: assert property (@(posedge clk) disable iff (rst)
    state == rbc_pkg::S_STEP && idx == last_idx |=> state == rbc_pkg::S_DONE)
    else $error("position advance did not finish on last rotor");

  a_data_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_is_data == $past(res_is_data))
    else $error("output flag does not match item kind");
`endif

endmodule
